// ===== hdl/sorted_multimap_table_defines.svh =====
// Assertion macros shared by the sorted multimap table modules.
// No dependencies.
`ifndef SORTED_MULTIMAP_TABLE_DEFINES_SVH
`define SORTED_MULTIMAP_TABLE_DEFINES_SVH
// assert that a implies b on every clock edge outside reset
`define SMT_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// assert that a implies b on the next clock edge
`define SMT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ===== hdl/smt_pkg.sv =====
// Shared types, constants and opcodes for the sorted multimap table.
// No dependencies.
package smt_pkg;
   localparam int Capacity = 1024;
   localparam int ValueWidth = 64;
   localparam int AddrW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);
   localparam int KeyW = 32;

   localparam logic [3:0] OP_INSERT = 4'd0;
   localparam logic [3:0] OP_LEFT   = 4'd1;
   localparam logic [3:0] OP_RIGHT  = 4'd2;
   localparam logic [3:0] OP_DELETE = 4'd3;
   localparam logic [3:0] OP_FLUSH  = 4'd4;
   localparam logic [3:0] OP_FKV    = 4'd5;
   localparam logic [3:0] OP_FKEY   = 4'd6;
   localparam logic [3:0] OP_FVAL   = 4'd7;
   localparam logic [3:0] OP_BKV    = 4'd8;
   localparam logic [3:0] OP_BKEY   = 4'd9;
   localparam logic [3:0] OP_BVAL   = 4'd10;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic             load;     // latch the request key and value
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic             wr_new;   // write the request entry, else the read entry
   } cmd_type;

   // datapath to controller: read entry compared against request
   typedef struct packed {
      logic key_lt;
      logic key_eq;
      logic val_eq;
   } stat_type;
endpackage

// ===== hdl/smt_datapath.sv =====
// Entry storage and compare logic of the sorted multimap table.
// Depends on smt_pkg and the assertion macros header.
`include "sorted_multimap_table_defines.svh"
module smt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  smt_pkg::cmd_type              cmd,
   input  logic [smt_pkg::KeyW-1:0]      key,
   input  logic [smt_pkg::ValueWidth-1:0] value,
   output smt_pkg::stat_type             stat
);
   import smt_pkg::*;

   logic [KeyW-1:0]       key_mem [Capacity];
   logic [ValueWidth-1:0] val_mem [Capacity];
   logic [KeyW-1:0]       rd_key_ff;
   logic [ValueWidth-1:0] rd_val_ff;
   logic                  rd_valid_ff;
   logic [KeyW-1:0]       key_ff;
   logic [ValueWidth-1:0] val_ff;
   logic [KeyW-1:0]       new_key;
   logic [ValueWidth-1:0] new_val;

   // the request is on the bus only in its accept cycle; hold it afterwards
   assign new_key = cmd.load ? key : key_ff;
   assign new_val = cmd.load ? value : val_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key;
         val_ff <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_mem[cmd.wr_addr] <= cmd.wr_new ? new_key : rd_key_ff;
         val_mem[cmd.wr_addr] <= cmd.wr_new ? new_val : rd_val_ff;
      end
      if (cmd.rd_en) begin
         rd_key_ff <= key_mem[cmd.rd_addr];
         rd_val_ff <= val_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else if (cmd.rd_en) rd_valid_ff <= 1'b1;
   end

   assign stat.key_lt = rd_key_ff < key_ff;
   assign stat.key_eq = rd_key_ff == key_ff;
   assign stat.val_eq = rd_val_ff == val_ff;

   `SMT_ASSERT_IMPL(a_no_rw_same, clock, reset, cmd.wr_en && cmd.rd_en && !cmd.wr_new,
      cmd.rd_addr != cmd.wr_addr)
   `SMT_ASSERT_NEXT(a_rd_valid, clock, reset, cmd.rd_en, rd_valid_ff)
   `SMT_ASSERT_IMPL(a_copy_after_read, clock, reset, cmd.wr_en && !cmd.wr_new, rd_valid_ff)
endmodule

// ===== hdl/smt_controller.sv =====
// Sequencer of the sorted multimap table: opcode decode, searches, shifts.
// Depends on smt_pkg and the assertion macros header.
`include "sorted_multimap_table_defines.svh"
module smt_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [3:0]                 opcode,
   input  logic [smt_pkg::CntW-1:0]   start_index,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [smt_pkg::CntW-1:0]   position,
   output logic                       not_found,
   output logic [1:0]                 status,
   output logic [smt_pkg::CntW-1:0]   entry_count,
   output smt_pkg::cmd_type           cmd,
   input  smt_pkg::stat_type          stat
);
   import smt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;  // read issued, wait for data
   localparam logic [2:0] S_EVAL  = 3'd2;  // data ready, decide
   localparam logic [2:0] S_SHIFT = 3'd3;  // issue read of next entry down, or write new entry at 0
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [3:0]      op_ff, op_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;   // linear / insert walk pointer
   logic [CntW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic            nf_ff, nf_in;
   logic [1:0]      st_ff, st_in;
   logic            busy_ff, busy_in;
   logic            rv_ff, rv_in;

   logic [CntW-1:0] mid;
   logic            skip;
   logic            fwd;
   logic [1:0]      mode;

   assign mid = CntW'((CntW+1)'(lo_ff) + (CntW+1)'(hi_ff) >> 1);
   assign fwd = op_ff inside {OP_FKV, OP_FKEY, OP_FVAL};
   assign mode = fwd ? 2'(op_ff - OP_FKV) : 2'(op_ff - OP_BKV);

   always_comb begin
      logic kpast;
      kpast = fwd ? stat.key_lt : (!stat.key_lt && !stat.key_eq);
      case (mode)
         2'd0:    skip = kpast || (stat.key_eq && !stat.val_eq);
         2'd1:    skip = kpast;
         default: skip = !stat.val_eq;
      endcase
   end

   assign req_tready  = !busy_ff;
   assign rsp_tvalid  = rv_ff;
   assign position    = pos_ff;
   assign not_found   = nf_ff;
   assign status      = st_ff;
   assign entry_count = count_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; count_in = count_ff; idx_in = idx_ff;
      lo_in = lo_ff; hi_in = hi_ff; pos_in = pos_ff; nf_in = nf_ff; st_in = st_ff;
      busy_in = busy_ff; rv_in = rv_ff;
      cmd = '0;
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
         busy_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               op_in = opcode; busy_in = 1'b1;
               pos_in = '0; nf_in = 1'b0; st_in = ST_OK;
               state_in = S_DONE;
               case (opcode)
                  OP_INSERT: begin
                     if (count_ff == CntW'(Capacity)) st_in = ST_FULL;
                     else if (count_ff == '0) begin
                        cmd.wr_en = 1'b1; cmd.wr_new = 1'b1; cmd.wr_addr = '0;
                        count_in = count_ff + 1'b1;
                     end else begin
                        idx_in = count_ff;
                        cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(count_ff - 1'b1);
                        state_in = S_READ;
                     end
                  end
                  OP_LEFT, OP_RIGHT: begin
                     lo_in = '0; hi_in = count_ff;
                     if (count_ff == '0) nf_in = (opcode == OP_RIGHT);
                     else state_in = S_READ;
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) st_in = ST_EMPTY;
                     else count_in = count_ff - 1'b1;
                  end
                  OP_FLUSH: count_in = '0;
                  OP_FKV, OP_FKEY, OP_FVAL: begin
                     if (count_ff == '0) nf_in = 1'b1;
                     else if (start_index > count_ff) begin
                        st_in = ST_RANGE; pos_in = count_ff;
                     end else if (start_index == count_ff) pos_in = count_ff;
                     else begin
                        idx_in = start_index;
                        cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(start_index);
                        state_in = S_READ;
                     end
                  end
                  OP_BKV, OP_BKEY, OP_BVAL: begin
                     if (count_ff == '0) nf_in = 1'b1;
                     else if (start_index >= count_ff) begin
                        st_in = ST_RANGE; nf_in = 1'b1;
                     end else begin
                        idx_in = start_index;
                        cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(start_index);
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            // binary searches issue their read here; others already did
            if (op_ff == OP_LEFT || op_ff == OP_RIGHT) begin
               cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(mid);
            end
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (op_ff)
               OP_INSERT: begin
                  // idx: slot being opened; read entry is idx-1
                  if (!stat.key_lt && !stat.key_eq) begin
                     cmd.wr_en = 1'b1; cmd.wr_addr = AddrW'(idx_ff);
                     idx_in = idx_ff - 1'b1;
                     state_in = S_SHIFT;
                  end else begin
                     cmd.wr_en = 1'b1; cmd.wr_new = 1'b1; cmd.wr_addr = AddrW'(idx_ff);
                     pos_in = idx_ff; count_in = count_ff + 1'b1;
                     state_in = S_DONE;
                  end
               end
               OP_LEFT, OP_RIGHT: begin
                  if (op_ff == OP_LEFT ? stat.key_lt : (stat.key_lt || stat.key_eq))
                     lo_in = mid + 1'b1;
                  else hi_in = mid;
                  state_in = S_READ;
                  if (lo_in == hi_in) begin
                     state_in = S_DONE;
                     if (op_ff == OP_LEFT) pos_in = lo_in;
                     else if (hi_in == '0) nf_in = 1'b1;
                     else pos_in = hi_in - 1'b1;
                  end
               end
               OP_FKV, OP_FKEY, OP_FVAL: begin
                  if (skip && (idx_ff + 1'b1) != count_ff) begin
                     idx_in = idx_ff + 1'b1;
                     cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(idx_in);
                     state_in = S_READ;
                  end else begin
                     pos_in = skip ? count_ff : idx_ff;
                     state_in = S_DONE;
                  end
               end
               default: begin
                  if (skip && idx_ff != '0) begin
                     idx_in = idx_ff - 1'b1;
                     cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(idx_in);
                     state_in = S_READ;
                  end else begin
                     if (skip) nf_in = 1'b1; else pos_in = idx_ff;
                     state_in = S_DONE;
                  end
               end
            endcase
         end
         S_SHIFT: begin
            if (idx_ff == '0) begin
               cmd.wr_en = 1'b1; cmd.wr_new = 1'b1; cmd.wr_addr = '0;
               pos_in = '0; count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(idx_ff - 1'b1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; busy_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; busy_ff <= busy_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; idx_ff <= idx_in; lo_ff <= lo_in; hi_ff <= hi_in;
      pos_ff <= pos_in; nf_ff <= nf_in; st_ff <= st_in;
   end

   `SMT_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CntW'(Capacity))
   `SMT_ASSERT_IMPL(a_rv_busy, clock, reset, rv_ff, busy_ff)
   `SMT_ASSERT_IMPL(a_idle_rv, clock, reset, rv_ff, state_ff == S_IDLE)
endmodule

// ===== hdl/sorted_multimap_table.sv =====
// Sorted multimap table: a sorted (key, value) table with binary and linear searches.
// Top level; instantiates smt_controller and smt_datapath, uses smt_pkg.
//
// Usage: one request transaction on req_* carries an opcode, key, value and start
// index; exactly one response transaction follows on rsp_*. One request is in
// flight at a time: req_tready is low from acceptance until the response is taken.
// Flush, delete and out-of-range or empty cases go from acceptance straight to S_DONE.
// Binary searches take one S_READ, S_EVAL pass per probe.
// Linear searches take one S_READ, S_EVAL pass per entry walked.
// Insert takes one S_READ, S_EVAL, S_SHIFT pass per entry shifted up; the walk is
// bound by the single read and single write port of the entry memory.
// Reset clears the entry count and the handshake state; entry memory holds no reset.
// A stalled receiver holds the response steady; no new request is taken until then.
module sorted_multimap_table (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,  // opcode[3:0], key[35:4], entry_value[99:36],
                                     // start_index[110:100], zero pad
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata   // position[10:0], not_found[11], status[13:12],
                                     // entry_count[24:14], zero pad
);
   import smt_pkg::*;

   cmd_type         cmd;
   stat_type        stat;
   logic [CntW-1:0] position, entry_count;
   logic            not_found;
   logic [1:0]      status;

   smt_controller u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .opcode(req_tdata[3:0]), .start_index(req_tdata[110:100]),
      .rsp_tvalid, .rsp_tready, .position, .not_found, .status, .entry_count,
      .cmd, .stat
   );

   smt_datapath u_dp (
      .clock, .reset, .cmd, .key(req_tdata[35:4]),
      .value(req_tdata[99:36]), .stat
   );

   assign rsp_tdata = {7'd0, entry_count, status, not_found, position};
endmodule
